// ===== rtl/cartesian_to_spherical_macros.svh =====
// ---------------------------------------------------------------------------
// cartesian_to_spherical assertion macros
// shorthand for the concurrent checks at the end of the top level
// ---------------------------------------------------------------------------
`ifndef CARTESIAN_TO_SPHERICAL_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_MACROS_SVH

// same-cycle implication
`define CTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cartesian_to_spherical: same-cycle check failed");

// next-cycle implication
`define CTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cartesian_to_spherical: next-cycle check failed");

`endif

// ===== rtl/cts_pkg.sv =====
// ---------------------------------------------------------------------------
// cts_pkg
// constants and the arctangent table shared by the spherical converter
// ---------------------------------------------------------------------------
package cts_pkg;

   localparam int GUARD_BITS = 8;
   localparam int TURN_W     = 32;
   localparam int OUT_W      = 16;
   localparam int GAIN_W     = 20;
   localparam int GAIN_SHIFT = 20;
   localparam logic [GAIN_W-1:0] K_INV  = 20'd636750;
   localparam logic [TURN_W-1:0] PI_TURN = 32'h8000_0000;

   // atan(2^-i) as a binary angle, 2^32 is a full turn
   function automatic logic [TURN_W-1:0] atan_turn(input int idx);
      logic [TURN_W-1:0] val;
      case (idx)
         0: val = 32'd536870912;
         1: val = 32'd316933406;
         2: val = 32'd167458907;
         3: val = 32'd85004756;
         4: val = 32'd42667331;
         5: val = 32'd21354465;
         6: val = 32'd10679838;
         7: val = 32'd5340245;
         8: val = 32'd2670163;
         9: val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         24: val = 32'd41;
         25: val = 32'd20;
         26: val = 32'd10;
         27: val = 32'd5;
         28: val = 32'd3;
         29: val = 32'd1;
         30: val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/cts_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// cts_cordic_cell
// one vectoring CORDIC iteration with a fixed shift, registered outputs
// ---------------------------------------------------------------------------
module cts_cordic_cell
   import cts_pkg::*;
#(
   parameter int DW    = 26,
   parameter int IDX   = 0,
   parameter int TAG_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [DW-1:0]     in_x,
   input  logic signed [DW-1:0]     in_y,
   input  logic [TURN_W-1:0]        in_ang,
   input  logic [TAG_W-1:0]         in_tag,
   output logic                     out_valid,
   output logic signed [DW-1:0]     out_x,
   output logic signed [DW-1:0]     out_y,
   output logic [TURN_W-1:0]        out_ang,
   output logic [TAG_W-1:0]         out_tag
);

   logic signed [DW-1:0] dx, dy;
   logic signed [DW-1:0] x_in, y_in;
   logic [TURN_W-1:0]    ang_in;
   logic                 valid_ff;
   logic signed [DW-1:0] x_ff, y_ff;
   logic [TURN_W-1:0]    ang_ff;
   logic [TAG_W-1:0]     tag_ff;

   // shifted cross terms
   assign dx = in_y >>> IDX;
   assign dy = in_x >>> IDX;

   // rotate toward the x axis
   always_comb begin
      if (!in_y[DW-1]) begin
         x_in   = in_x + dx;
         y_in   = in_y - dy;
         ang_in = in_ang + atan_turn(IDX);
      end else begin
         x_in   = in_x - dx;
         y_in   = in_y + dy;
         ang_in = in_ang - atan_turn(IDX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      ang_ff <= ang_in;
      tag_ff <= in_tag;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_ang   = ang_ff;
   assign out_tag   = tag_ff;

endmodule

// ===== rtl/cts_gain.sv =====
// ---------------------------------------------------------------------------
// cts_gain
// removes the CORDIC gain: clamp at zero, scale by 1/K, round half up
// ---------------------------------------------------------------------------
module cts_gain
   import cts_pkg::*;
#(
   parameter int DW    = 26,
   parameter int TAG_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [DW-1:0] in_v,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [DW-1:0]        out_v,
   output logic [TAG_W-1:0]     out_tag
);

   localparam int PW = DW + GAIN_W;

   logic [DW-2:0]    mag;
   logic [PW-1:0]    prod;
   logic [DW-1:0]    v_in;
   logic             valid_ff;
   logic [DW-1:0]    v_ff;
   logic [TAG_W-1:0] tag_ff;

   // negative values count as zero
   assign mag  = in_v[DW-1] ? '0 : in_v[DW-2:0];
   assign prod = PW'(mag) * PW'(K_INV) + (PW'(1) << (GAIN_SHIFT - 1));
   assign v_in = DW'(prod >> GAIN_SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      tag_ff <= in_tag;
   end

   assign out_valid = valid_ff;
   assign out_v     = v_ff;
   assign out_tag   = tag_ff;

endmodule

// ===== rtl/cartesian_to_spherical.sv =====
// ---------------------------------------------------------------------------
// cartesian_to_spherical
// 3D point to azimuth, elevation and range through two CORDIC cell chains
// ---------------------------------------------------------------------------
//  channel   handshake            word
//  request   start / busy         req_x_coord, req_y_coord, req_z_coord
//  response  rsp_valid (strobe)   rsp_azimuth, rsp_elevation, rsp_radius,
//                                 rsp_zero_range
//
// one word per cycle; words pass the entry register, the first CORDIC chain
// and its gain multiplier, the second chain and its gain multiplier, then
// the output register. busy is always low. synchronous reset empties the
// pipeline; no state survives between words, and results are not held.
module cartesian_to_spherical
   import cts_pkg::*;
#(
   parameter int COORD_WIDTH   = 16,
   parameter int ANGLE_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_x_coord,
   input  logic signed [COORD_WIDTH-1:0] req_y_coord,
   input  logic signed [COORD_WIDTH-1:0] req_z_coord,
   output logic                          rsp_valid,
   output logic [OUT_W-1:0]              rsp_azimuth,
   output logic signed [OUT_W-1:0]       rsp_elevation,
   output logic [OUT_W-1:0]              rsp_radius,
   output logic                          rsp_zero_range
);

`include "cartesian_to_spherical_macros.svh"

   localparam int CW    = COORD_WIDTH;
   localparam int DW    = COORD_WIDTH + GUARD_BITS + 2;
   localparam int N     = CORDIC_STAGES;
   localparam int SH    = TURN_W - ANGLE_WIDTH;
   localparam int SH_M1 = (SH > 0) ? SH - 1 : 0;
   localparam logic [TURN_W-1:0] HALF = (SH > 0) ? (TURN_W'(1) << SH_M1) : '0;
   localparam int TAG1  = 2 + CW;
   localparam int TAGG1 = TAG1 + TURN_W;
   localparam int TAG2  = 1 + TURN_W;
   localparam int TAGG2 = TAG2 + TURN_W;
   localparam logic signed [TURN_W+1:0] E_MAX = 34'sd1073741824;
   localparam logic signed [TURN_W+1:0] E_MIN = -34'sd1073741824;

   logic accept;
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   // entry: widen, fold the left half plane, spot the special points
   logic signed [DW-1:0] rx_w, ry_w;
   logic                 origin_w, xyzero_w;
   logic                 s0_valid_ff;
   logic signed [DW-1:0] s0_x_ff, s0_y_ff;
   logic [TURN_W-1:0]    s0_ang_ff;
   logic [TAG1-1:0]      s0_tag_ff;

   assign rx_w = {{(DW-CW-GUARD_BITS){req_x_coord[CW-1]}}, req_x_coord, {GUARD_BITS{1'b0}}};
   assign ry_w = {{(DW-CW-GUARD_BITS){req_y_coord[CW-1]}}, req_y_coord, {GUARD_BITS{1'b0}}};
   assign xyzero_w = (req_x_coord == '0) && (req_y_coord == '0);
   assign origin_w = xyzero_w && (req_z_coord == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_x_coord[CW-1]) begin
         s0_x_ff   <= -rx_w;
         s0_y_ff   <= -ry_w;
         s0_ang_ff <= PI_TURN;
      end else begin
         s0_x_ff   <= rx_w;
         s0_y_ff   <= ry_w;
         s0_ang_ff <= '0;
      end
      s0_tag_ff <= {origin_w, xyzero_w, req_z_coord};
   end

   // first chain: atan2(y, x) and planar length
   logic                 c1_valid [N+1];
   logic signed [DW-1:0] c1_x     [N+1];
   logic signed [DW-1:0] c1_y     [N+1];
   logic [TURN_W-1:0]    c1_ang   [N+1];
   logic [TAG1-1:0]      c1_tag   [N+1];

   assign c1_valid[0] = s0_valid_ff;
   assign c1_x[0]     = s0_x_ff;
   assign c1_y[0]     = s0_y_ff;
   assign c1_ang[0]   = s0_ang_ff;
   assign c1_tag[0]   = s0_tag_ff;

   for (genvar i = 0; i < N; i++) begin : g_chain1
      cts_cordic_cell #(.DW(DW), .IDX(i), .TAG_W(TAG1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c1_valid[i]),
         .in_x      (c1_x[i]),
         .in_y      (c1_y[i]),
         .in_ang    (c1_ang[i]),
         .in_tag    (c1_tag[i]),
         .out_valid (c1_valid[i+1]),
         .out_x     (c1_x[i+1]),
         .out_y     (c1_y[i+1]),
         .out_ang   (c1_ang[i+1]),
         .out_tag   (c1_tag[i+1])
      );
   end

   // planar length gain
   logic             g1_valid;
   logic [DW-1:0]    g1_v;
   logic [TAGG1-1:0] g1_tag;

   cts_gain #(.DW(DW), .TAG_W(TAGG1)) u_gain1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c1_valid[N]),
      .in_v      (c1_x[N]),
      .in_tag    ({c1_tag[N], c1_ang[N]}),
      .out_valid (g1_valid),
      .out_v     (g1_v),
      .out_tag   (g1_tag)
   );

   // second chain entry: (planar length, z)
   logic                 g1_origin, g1_xyzero;
   logic [CW-1:0]        g1_z;
   logic [TURN_W-1:0]    g1_ang, az_w;

   assign {g1_origin, g1_xyzero, g1_z, g1_ang} = g1_tag;
   assign az_w = g1_xyzero ? '0 : g1_ang;

   logic                 c2_valid [N+1];
   logic signed [DW-1:0] c2_x     [N+1];
   logic signed [DW-1:0] c2_y     [N+1];
   logic [TURN_W-1:0]    c2_ang   [N+1];
   logic [TAG2-1:0]      c2_tag   [N+1];

   assign c2_valid[0] = g1_valid;
   assign c2_x[0]     = g1_v;
   assign c2_y[0]     = {{(DW-CW-GUARD_BITS){g1_z[CW-1]}}, g1_z, {GUARD_BITS{1'b0}}};
   assign c2_ang[0]   = '0;
   assign c2_tag[0]   = {g1_origin, az_w};

   for (genvar i = 0; i < N; i++) begin : g_chain2
      cts_cordic_cell #(.DW(DW), .IDX(i), .TAG_W(TAG2)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c2_valid[i]),
         .in_x      (c2_x[i]),
         .in_y      (c2_y[i]),
         .in_ang    (c2_ang[i]),
         .in_tag    (c2_tag[i]),
         .out_valid (c2_valid[i+1]),
         .out_x     (c2_x[i+1]),
         .out_y     (c2_y[i+1]),
         .out_ang   (c2_ang[i+1]),
         .out_tag   (c2_tag[i+1])
      );
   end

   // range gain
   logic             g2_valid;
   logic [DW-1:0]    g2_v;
   logic [TAGG2-1:0] g2_tag;

   cts_gain #(.DW(DW), .TAG_W(TAGG2)) u_gain2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c2_valid[N]),
      .in_v      (c2_x[N]),
      .in_tag    ({c2_tag[N], c2_ang[N]}),
      .out_valid (g2_valid),
      .out_v     (g2_v),
      .out_tag   (g2_tag)
   );

   // output rounding and saturation
   logic                     g2_origin;
   logic [TURN_W-1:0]        g2_az, g2_el;
   logic [TURN_W-1:0]        az_sum, az_rnd;
   logic signed [TURN_W+1:0] el_ext, el_clamp, el_rnd;
   logic [DW:0]              rad_rnd;
   logic [OUT_W-1:0]         azimuth_in, elevation_in, radius_in;

   assign {g2_origin, g2_az, g2_el} = g2_tag;
   assign az_sum = g2_az + PI_TURN;
   assign az_rnd = (az_sum + HALF) >> SH;
   assign el_ext = {{2{g2_el[TURN_W-1]}}, g2_el};

   always_comb begin
      if (el_ext > E_MAX) begin
         el_clamp = E_MAX;
      end else if (el_ext < E_MIN) begin
         el_clamp = E_MIN;
      end else begin
         el_clamp = el_ext;
      end
   end

   assign el_rnd  = (el_clamp + $signed({2'b00, HALF})) >>> SH;
   assign rad_rnd = ({1'b0, g2_v} + (DW+1)'(1 << (GUARD_BITS - 1))) >> GUARD_BITS;

   assign azimuth_in   = az_rnd[OUT_W-1:0];
   assign elevation_in = g2_origin ? '0 : el_rnd[OUT_W-1:0];
   assign radius_in    = (rad_rnd > (DW+1)'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
                                                             : rad_rnd[OUT_W-1:0];

   logic             rsp_valid_ff, rsp_zero_ff;
   logic [OUT_W-1:0] rsp_az_ff, rsp_el_ff, rsp_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_zero_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= g2_valid;
         rsp_zero_ff  <= g2_valid & g2_origin;
      end
   end

   always_ff @(posedge clock) begin
      rsp_az_ff  <= azimuth_in;
      rsp_el_ff  <= elevation_in;
      rsp_rad_ff <= radius_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_azimuth    = rsp_az_ff;
   assign rsp_elevation  = rsp_el_ff;
   assign rsp_radius     = rsp_rad_ff;
   assign rsp_zero_range = rsp_zero_ff;

   // checks
   `CTS_ASSERT_IMPLY(a_origin_out, clock, reset, rsp_zero_range, rsp_valid && rsp_radius == '0 && rsp_elevation == '0)
   `CTS_ASSERT_NEXT(a_take, clock, reset, accept, s0_valid_ff)
   `CTS_ASSERT_NEXT(a_origin_flag, clock, reset, g2_valid && g2_origin, rsp_zero_range)

endmodule
